/* rtl/bmg_pkg.sv */
// ----------------------------------------------------------------------------
// bmg_pkg
// Shared constants, tables and types for the Box-Muller gaussian generator.
// ----------------------------------------------------------------------------
package bmg_pkg;

   // number of rotation stages requested and actually built
   localparam int CORDIC_STAGES = 24;
   localparam int CORDIC_N      = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

   // fraction bits of the log and radius
   localparam int LOG_FRAC = 26;

   // digits of the square root result (58-bit radicand)
   localparam int SQRT_N = 29;

   // 2 ln 2 in Q2.30 and inverse rotation gain in Q0.32
   localparam logic [31:0] TWO_LN2_Q30 = 32'd1488522236;
   localparam logic [31:0] KINV_Q32    = 32'd2608131496;

   // register indexes on the csr port
   localparam logic REG_MEAN = 1'b0;
   localparam logic REG_STD  = 1'b1;

   // arctangent of 2^-i in units of 2^-32 of a full turn
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   // side data that travels with each beat through the pipeline
   typedef struct packed {
      logic        clip;
      logic [31:0] angle;
   } tag_type;

endpackage

/* rtl/bmg_log.sv */
// ----------------------------------------------------------------------------
// bmg_log
// Normalizes the radius word, takes log2 by repeated squaring and scales
// the result to -2 ln u1 in Q.26.
// ----------------------------------------------------------------------------
module bmg_log (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  bmg_pkg::tag_type in_tag,
   input  logic [31:0]      radius_word,
   output logic             out_valid,
   output bmg_pkg::tag_type out_tag,
   output logic [31:0]      x_val
);

   localparam int L = bmg_pkg::LOG_FRAC;

   logic                   vld_ff [0:L];
   logic [31:0]            m_ff   [0:L];
   logic [L-1:0]           f_ff   [0:L];
   logic [5:0]             e_ff   [0:L];
   bmg_pkg::tag_type       tg_ff  [0:L];

   logic [31:0]            w_sel;
   logic [4:0]             k_sel;
   logic [31:0]            m_in;
   bmg_pkg::tag_type       tag_in;

   // zero word clamps to one, then find leading one and normalize
   always_comb begin
      w_sel  = (radius_word == 32'd0) ? 32'd1 : radius_word;
      k_sel  = 5'd0;
      for (int b = 0; b < 32; b++) begin
         if (w_sel[b]) begin
            k_sel = 5'(b);
         end
      end
      m_in        = w_sel << (5'd31 - k_sel);
      tag_in      = in_tag;
      tag_in.clip = in_tag.clip | (radius_word == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]  <= m_in;
         f_ff[0]  <= '0;
         e_ff[0]  <= 6'd32 - {1'b0, k_sel};
         tg_ff[0] <= tag_in;
      end
   end

   // one squaring step per stage, one fraction bit each
   for (genvar i = 0; i < L; i++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] t;
      logic [31:0] mn;
      logic        bit_out;

      always_comb begin
         sq      = {32'd0, m_ff[i]} * {32'd0, m_ff[i]};
         t       = sq[63:31];
         bit_out = t[32];
         mn      = bit_out ? t[32:1] : t[31:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[i+1]  <= mn;
            f_ff[i+1]  <= {f_ff[i][L-2:0], bit_out};
            e_ff[i+1]  <= e_ff[i];
            tg_ff[i+1] <= tg_ff[i];
         end
      end
   end

   logic             lg_vld_ff;
   logic [31:0]      lg_ff;
   bmg_pkg::tag_type lg_tag_ff;
   logic             x_vld_ff;
   logic [31:0]      x_ff;
   bmg_pkg::tag_type x_tag_ff;
   logic [63:0]      x_prod;

   // -log2(u1) = exponent - fraction, then times 2 ln 2
   always_comb begin
      x_prod = {32'd0, lg_ff} * {32'd0, bmg_pkg::TWO_LN2_Q30};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_vld_ff <= 1'b0;
         x_vld_ff  <= 1'b0;
      end else if (en) begin
         lg_vld_ff <= vld_ff[L];
         x_vld_ff  <= lg_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lg_ff     <= {e_ff[L], {L{1'b0}}} - {6'd0, f_ff[L]};
         lg_tag_ff <= tg_ff[L];
         x_ff      <= x_prod[61:30];
         x_tag_ff  <= lg_tag_ff;
      end
   end

   assign out_valid = x_vld_ff;
   assign out_tag   = x_tag_ff;
   assign x_val     = x_ff;

endmodule

/* rtl/bmg_sqrt.sv */
// ----------------------------------------------------------------------------
// bmg_sqrt
// Digit-by-digit integer square root of x << 26, one result bit per stage.
// ----------------------------------------------------------------------------
module bmg_sqrt (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  bmg_pkg::tag_type in_tag,
   input  logic [31:0]      x_val,
   output logic             out_valid,
   output bmg_pkg::tag_type out_tag,
   output logic [28:0]      root
);

   localparam int N = bmg_pkg::SQRT_N;

   logic             vld_ff  [0:N];
   logic [31:0]      rem_ff  [0:N];
   logic [28:0]      root_ff [0:N];
   logic [31:0]      xs_ff   [0:N];
   bmg_pkg::tag_type tg_ff   [0:N];

   assign vld_ff[0]  = in_valid;
   assign rem_ff[0]  = '0;
   assign root_ff[0] = '0;
   assign xs_ff[0]   = x_val;
   assign tg_ff[0]   = in_tag;

   // radicand pairs come from x first, then from the zero low bits
   for (genvar j = 0; j < N; j++) begin : g_dig
      logic [31:0] r4;
      logic [31:0] trial;
      logic        ge;

      always_comb begin
         r4    = {rem_ff[j][29:0], xs_ff[j][31:30]};
         trial = {1'b0, root_ff[j], 2'b01};
         ge    = (r4 >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (en) begin
            vld_ff[j+1] <= vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1]  <= ge ? (r4 - trial) : r4;
            root_ff[j+1] <= {root_ff[j][27:0], ge};
            xs_ff[j+1]   <= {xs_ff[j][29:0], 2'b00};
            tg_ff[j+1]   <= tg_ff[j];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_tag   = tg_ff[N];
   assign root      = root_ff[N];

endmodule

/* rtl/bmg_cordic.sv */
// ----------------------------------------------------------------------------
// bmg_cordic
// Applies the inverse gain to the radius and rotates it through the low
// 30 angle bits, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module bmg_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  bmg_pkg::tag_type   in_tag,
   input  logic [28:0]        root,
   output logic               out_valid,
   output bmg_pkg::tag_type   out_tag,
   output logic signed [31:0] cx,
   output logic signed [31:0] cy
);

   localparam int N = bmg_pkg::CORDIC_N;

   logic                vld_ff [0:N];
   logic signed [31:0]  x_ff   [0:N];
   logic signed [31:0]  y_ff   [0:N];
   logic signed [32:0]  z_ff   [0:N];
   bmg_pkg::tag_type    tg_ff  [0:N];
   logic [60:0]         g_prod;

   // gain compensation
   always_comb begin
      g_prod = {32'd0, root} * {29'd0, bmg_pkg::KINV_Q32};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]  <= $signed({3'd0, g_prod[60:32]});
         y_ff[0]  <= '0;
         z_ff[0]  <= $signed({3'd0, in_tag.angle[29:0]});
         tg_ff[0] <= in_tag;
      end
   end

   // micro-rotations with floor shifts
   for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [31:0] xs;
      logic signed [31:0] ys;
      logic signed [32:0] at;

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         at = $signed({1'b0, bmg_pkg::ATAN_TURNS[i]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][32]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + at;
            end
            tg_ff[i+1] <= tg_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_tag   = tg_ff[N];
   assign cx        = x_ff[N];
   assign cy        = y_ff[N];

endmodule

/* rtl/bmg_scale.sv */
// ----------------------------------------------------------------------------
// bmg_scale
// Quadrant fold, scaling by the standard deviation, mean offset and
// saturation into the result register.
// ----------------------------------------------------------------------------
module bmg_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  bmg_pkg::tag_type   in_tag,
   input  logic signed [31:0] cx,
   input  logic signed [31:0] cy,
   input  logic [31:0]        mean_offset,
   input  logic [30:0]        std_scale,
   output logic               out_valid,
   output logic [31:0]        normal_cos,
   output logic [31:0]        normal_sin,
   output logic               clipped
);

   logic               sel_vld_ff;
   logic signed [31:0] c_ff;
   logic signed [31:0] s_ff;
   logic               sel_clip_ff;
   logic signed [31:0] c_in;
   logic signed [31:0] s_in;

   // quadrant from the top two angle bits
   always_comb begin
      unique case (in_tag.angle[31:30])
         2'd0: begin
            c_in = cx;
            s_in = cy;
         end
         2'd1: begin
            c_in = -cy;
            s_in = cx;
         end
         2'd2: begin
            c_in = -cx;
            s_in = -cy;
         end
         default: begin
            c_in = cy;
            s_in = -cx;
         end
      endcase
   end

   logic               mul_vld_ff;
   logic signed [63:0] pc_ff;
   logic signed [63:0] ps_ff;
   logic               mul_clip_ff;
   logic signed [31:0] sd;

   assign sd = $signed({1'b0, std_scale});

   logic               add_vld_ff;
   logic signed [38:0] sc_ff;
   logic signed [38:0] ss_ff;
   logic               add_clip_ff;
   logic signed [63:0] adj_c;
   logic signed [63:0] adj_s;
   logic signed [38:0] sc_in;
   logic signed [38:0] ss_in;

   // truncate toward zero by 2^26, then add the mean
   always_comb begin
      adj_c = pc_ff + (pc_ff[63] ? 64'sd67108863 : 64'sd0);
      adj_s = ps_ff + (ps_ff[63] ? 64'sd67108863 : 64'sd0);
      sc_in = $signed({adj_c[63], adj_c[63:26]}) +
              $signed({{7{mean_offset[31]}}, mean_offset});
      ss_in = $signed({adj_s[63], adj_s[63:26]}) +
              $signed({{7{mean_offset[31]}}, mean_offset});
   end

   logic        over_c;
   logic        under_c;
   logic        over_s;
   logic        under_s;
   logic [31:0] cos_in;
   logic [31:0] sin_in;

   // saturate to signed 32 bits
   always_comb begin
      over_c  = !sc_ff[38] && (|sc_ff[37:31]);
      under_c = sc_ff[38] && !(&sc_ff[37:31]);
      over_s  = !ss_ff[38] && (|ss_ff[37:31]);
      under_s = ss_ff[38] && !(&ss_ff[37:31]);
      cos_in  = over_c ? 32'h7fff_ffff : (under_c ? 32'h8000_0000 : sc_ff[31:0]);
      sin_in  = over_s ? 32'h7fff_ffff : (under_s ? 32'h8000_0000 : ss_ff[31:0]);
   end

   logic        out_vld_ff;
   logic [31:0] cos_ff;
   logic [31:0] sin_ff;
   logic        clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_vld_ff <= 1'b0;
         mul_vld_ff <= 1'b0;
         add_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         sel_vld_ff <= in_valid;
         mul_vld_ff <= sel_vld_ff;
         add_vld_ff <= mul_vld_ff;
         out_vld_ff <= add_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff        <= c_in;
         s_ff        <= s_in;
         sel_clip_ff <= in_tag.clip;
         pc_ff       <= c_ff * sd;
         ps_ff       <= s_ff * sd;
         mul_clip_ff <= sel_clip_ff;
         sc_ff       <= sc_in;
         ss_ff       <= ss_in;
         add_clip_ff <= mul_clip_ff;
         cos_ff      <= cos_in;
         sin_ff      <= sin_in;
         clip_ff     <= add_clip_ff | over_c | under_c | over_s | under_s;
      end
   end

   assign out_valid  = out_vld_ff;
   assign normal_cos = cos_ff;
   assign normal_sin = sin_ff;
   assign clipped    = clip_ff;

endmodule

/* rtl/box_muller_gaussian.sv */
// throughput: one beat per cycle while no result beat is held; log squaring, root digits
// and rotations are each one register stage, so a new beat enters every cycle
// a held result stalls the whole pipeline; nothing is dropped or repeated
// reset: synchronous, clears all valid bits; mean_offset to 0, std_scale to 1
// ----------------------------------------------------------------------------
// box_muller_gaussian
// Pipelined fixed-point Box-Muller transform with an APB-style csr port.
// ----------------------------------------------------------------------------
module box_muller_gaussian (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_radius_word,
   input  logic [31:0] req_angle_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_normal_cos,
   output logic [31:0] rsp_normal_sin,
   output logic        rsp_clipped,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic        en;
   logic [31:0] mean_ff;
   logic [30:0] std_ff;

   // pipeline advances unless a result beat is waiting
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // csr registers
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
         std_ff  <= 31'd1;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            bmg_pkg::REG_MEAN: mean_ff <= pwdata;
            bmg_pkg::REG_STD:  std_ff  <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         bmg_pkg::REG_MEAN: prdata = mean_ff;
         bmg_pkg::REG_STD:  prdata = {1'b0, std_ff};
         default:           prdata = '0;
      endcase
   end

   bmg_pkg::tag_type in_tag;
   assign in_tag = '{clip: 1'b0, angle: req_angle_word};

   logic             log_vld;
   bmg_pkg::tag_type log_tag;
   logic [31:0]      log_x;

   bmg_log u_log (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .in_tag      (in_tag),
      .radius_word (req_radius_word),
      .out_valid   (log_vld),
      .out_tag     (log_tag),
      .x_val       (log_x)
   );

   logic             sq_vld;
   bmg_pkg::tag_type sq_tag;
   logic [28:0]      sq_root;

   bmg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (log_vld),
      .in_tag    (log_tag),
      .x_val     (log_x),
      .out_valid (sq_vld),
      .out_tag   (sq_tag),
      .root      (sq_root)
   );

   logic               rot_vld;
   bmg_pkg::tag_type   rot_tag;
   logic signed [31:0] rot_x;
   logic signed [31:0] rot_y;

   bmg_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_vld),
      .in_tag    (sq_tag),
      .root      (sq_root),
      .out_valid (rot_vld),
      .out_tag   (rot_tag),
      .cx        (rot_x),
      .cy        (rot_y)
   );

   bmg_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (rot_vld),
      .in_tag      (rot_tag),
      .cx          (rot_x),
      .cy          (rot_y),
      .mean_offset (mean_ff),
      .std_scale   (std_ff),
      .out_valid   (rsp_valid),
      .normal_cos  (rsp_normal_cos),
      .normal_sin  (rsp_normal_sin),
      .clipped     (rsp_clipped)
   );

endmodule

/* rtl/bmg_check.sv */
// ----------------------------------------------------------------------------
// bmg_check
// Port-level checks for the gaussian generator, bound to the top level.
// ----------------------------------------------------------------------------
module bmg_check (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_normal_cos,
   input logic [31:0] rsp_normal_sin,
   input logic        rsp_clipped,
   input logic        pready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_cos) &&
      $stable(rsp_normal_sin) && $stable(rsp_clipped))
      else $error("result beat changed while stalled");

   // input side follows the output stall
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready out of step with result stall");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // csr port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind box_muller_gaussian bmg_check u_bmg_check (.*);
